// ----- design/sacl_pkg.sv -----
// Shared constants for the set-associative cache tag and LRU store.
package sacl_pkg;

  localparam int unsigned AddrW         = 32;
  localparam int unsigned DefWays       = 4;
  localparam int unsigned DefSets       = 64;
  localparam int unsigned DefLineBytes  = 32;

endpackage

// ----- design/sacl_way_sel.sv -----
// Hit detection, victim choice and recency update for one set row.
module sacl_way_sel import sacl_pkg::*; #(
  parameter int unsigned WAYS  = DefWays,
  parameter int unsigned TAG_W = 21,
  localparam int unsigned WayW = $clog2(WAYS)
) (
  input  logic [WAYS-1:0]             valid_i,
  input  logic [WAYS-1:0][WayW-1:0]   rank_i,
  input  logic [WAYS-1:0][TAG_W-1:0]  tags_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        hit_o,
  output logic [WayW-1:0]             way_o,
  output logic [WAYS-1:0]             valid_o,
  output logic [WAYS-1:0][WayW-1:0]   rank_o,
  output logic [WAYS-1:0][TAG_W-1:0]  tags_o
);

  logic [WAYS-1:0] match;
  logic [WayW-1:0] hit_way;
  logic [WayW-1:0] inv_way;
  logic            any_inv;
  logic [WayW-1:0] lru_way;
  logic [WayW-1:0] best_rank;
  logic [WayW-1:0] old_rank;

  always_comb begin
    match   = '0;
    hit_way = '0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_i[w] && (tags_i[w] == tag_i);
    end
    // lowest index wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WayW'(w);
      if (!valid_i[w]) inv_way = WayW'(w);
    end
    any_inv = ~&valid_i;

    // least recent way, lowest index on ties
    best_rank = rank_i[0];
    lru_way   = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (rank_i[w] < best_rank) begin
        best_rank = rank_i[w];
        lru_way   = WayW'(w);
      end
    end

    hit_o = |match;
    if (hit_o) begin
      way_o = hit_way;
    end else if (any_inv) begin
      way_o = inv_way;
    end else begin
      way_o = lru_way;
    end

    valid_o = valid_i;
    tags_o  = tags_i;
    if (!hit_o) begin
      valid_o[way_o] = 1'b1;
      tags_o[way_o]  = tag_i;
    end

    old_rank = rank_i[way_o];
    for (int w = 0; w < WAYS; w++) begin
      rank_o[w] = (rank_i[w] > old_rank) ? rank_i[w] - WayW'(1) : rank_i[w];
    end
    rank_o[way_o] = WayW'(WAYS - 1);
  end

endmodule

// ----- design/set_assoc_cache_tag_lru.sv -----
// Top level: tag store and LRU replacement control of a set-associative I-cache.
// Looks up a fetch address in a WAYS-way, SETS-set tag store of LINE_BYTES-byte
// lines. The address splits into line offset, set index and tag; a valid way
// whose tag matches is a hit. On a miss the lowest invalid way is refilled, or
// else the least recent way, and the accessed way becomes most recent. All
// state of a set (tags, valid bits, recency ranks) sits in one row of a single
// synchronous memory with a registered read. After reset the block runs a
// clearing pass over all SETS rows, writing one row per cycle, with in_ready_o
// low. In each transaction the accept cycle issues the row read; the lookup
// state then compares, picks the way, writes the row back and loads the output
// register. A result parked in the output register does not block the next
// accept; a new result waits in the lookup state only while the previous one
// is still untaken. Since the write-back finishes before the next row read,
// accesses to one set never overlap.
module set_assoc_cache_tag_lru import sacl_pkg::*; #(
  parameter int unsigned WAYS       = DefWays,
  parameter int unsigned SETS       = DefSets,
  parameter int unsigned LINE_BYTES = DefLineBytes,
  localparam int unsigned WayW = $clog2(WAYS),
  localparam int unsigned SetW = $clog2(SETS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [AddrW-1:0] fetch_address_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             hit_o,
  output logic [WayW-1:0]  way_used_o,
  output logic [SetW-1:0]  set_index_o
);

  localparam int unsigned OffW = $clog2(LINE_BYTES);
  localparam int unsigned TagW = AddrW - OffW - SetW;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

  typedef struct packed {
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][WayW-1:0]  rank;
    logic [WAYS-1:0][TagW-1:0]  tags;
  } row_t;

  state_e state_q, state_d;
  logic [SetW-1:0] clr_cnt_q, clr_cnt_d;

  // Transaction address, held from accept through lookup.
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;

  // Set memory.
  row_t mem_q [SETS];
  row_t rdata_q;
  row_t wdata;
  logic            mem_we;
  logic [SetW-1:0] mem_waddr;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic            hit_q;
  logic [WayW-1:0] way_q;
  logic [SetW-1:0] oset_q;

  logic            in_acc;
  logic            out_free;
  logic            lookup_done;
  logic            sel_hit;
  logic [WayW-1:0] sel_way;
  row_t            upd_row;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign lookup_done = (state_q == ST_LOOKUP) && out_free;

  sacl_way_sel #(
    .WAYS  (WAYS),
    .TAG_W (TagW)
  ) u_way_sel (
    .valid_i (rdata_q.valid),
    .rank_i  (rdata_q.rank),
    .tags_i  (rdata_q.tags),
    .tag_i   (tag_q),
    .hit_o   (sel_hit),
    .way_o   (sel_way),
    .valid_o (upd_row.valid),
    .rank_o  (upd_row.rank),
    .tags_o  (upd_row.tags)
  );

  // Write port: clearing pass, or write-back of the looked-up set.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_q;
    wdata     = upd_row;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      wdata     = '0;
    end else if (lookup_done) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= wdata;
    end
    if (in_acc) begin
      rdata_q <= mem_q[fetch_address_i[OffW +: SetW]];
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + SetW'(1);
        if (clr_cnt_q == SetW'(SETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q <= fetch_address_i[OffW +: SetW];
      tag_q <= fetch_address_i[AddrW-1 -: TagW];
    end
    if (lookup_done) begin
      hit_q  <= sel_hit;
      way_q  <= sel_way;
      oset_q <= set_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign way_used_o  = way_q;
  assign set_index_o = oset_q;

  // A transaction always moves on to the lookup state.
  a_acc_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_LOOKUP)
    else $error("accept not followed by lookup");

  // The row memory is never written while idle, so reads never race writes.
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != ST_IDLE)
    else $error("row write while idle");

  // The accessed way is written back valid and most recent.
  a_touch_mru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_done |-> upd_row.valid[sel_way] && (upd_row.rank[sel_way] == WayW'(WAYS - 1)))
    else $error("accessed way not valid and most recent");

  // A result is loaded in the cycle after its lookup completes.
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lookup_done |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not loaded after lookup");

endmodule

// ----- verif/set_assoc_cache_tag_lru_checker.sv -----
// Checker: mirrors the cache tag/LRU state and compares each lookup result.
`timescale 1ns / 100ps

module set_assoc_cache_tag_lru_checker import sacl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [AddrW-1:0] fetch_address_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic             hit_i,
  input  logic [1:0]       way_used_i,
  input  logic [5:0]       set_index_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o,
  output int unsigned      hits_o
);

  localparam int unsigned WAYS     = DefWays;
  localparam int unsigned SETS     = DefSets;
  localparam int unsigned WayW     = $clog2(DefWays);
  localparam int unsigned SetW     = $clog2(DefSets);
  localparam int unsigned OffW     = $clog2(DefLineBytes);
  localparam int unsigned TagW     = AddrW - OffW - SetW;
  localparam int unsigned Lines    = WAYS * SETS;
  localparam int unsigned MaxPrint = 30;

  typedef struct packed {
    logic            hit;
    logic [WayW-1:0] way;
    logic [SetW-1:0] set_idx;
  } lookup_t;

  // Shadow tag store, indexed set*WAYS + way.
  logic [TagW-1:0] line_tag   [Lines];
  logic            line_valid [Lines];
  logic [WayW-1:0] line_rank  [Lines];

  lookup_t lookup_q[$];

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors_o < MaxPrint) begin
      $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    end
    errors_o++;
  endtask

  // Hit search, victim choice on miss, then LRU touch of the accessed way.
  function automatic lookup_t predict_lookup(input logic [AddrW-1:0] addr);
    lookup_t         r;
    logic [SetW-1:0] set_idx;
    logic [TagW-1:0] tag;
    int unsigned     base;
    logic [WayW-1:0] old_rank;
    bit              found;
    set_idx   = addr[OffW +: SetW];
    tag       = addr[AddrW-1 -: TagW];
    base      = set_idx * WAYS;
    r         = '0;
    r.set_idx = set_idx;
    for (int w = 0; w < WAYS; w++) begin
      if (!r.hit && line_valid[base + w] && line_tag[base + w] == tag) begin
        r.hit = 1'b1;
        r.way = WayW'(w);
      end
    end
    if (!r.hit) begin
      found = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
        if (!found && !line_valid[base + w]) begin
          found = 1'b1;
          r.way = WayW'(w);
        end
      end
      // full set: least recent way, lowest index on a tie
      if (!found) begin
        r.way = '0;
        for (int w = 1; w < WAYS; w++) begin
          if (line_rank[base + w] < line_rank[base + r.way]) r.way = WayW'(w);
        end
      end
      line_tag[base + r.way]   = tag;
      line_valid[base + r.way] = 1'b1;
    end
    old_rank = line_rank[base + r.way];
    for (int w = 0; w < WAYS; w++) begin
      if (line_rank[base + w] > old_rank) line_rank[base + w] = line_rank[base + w] - WayW'(1);
    end
    line_rank[base + r.way] = WayW'(WAYS - 1);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Lines; i++) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        line_rank[i]  = '0;
      end
      lookup_q.delete();
      errors_o  = 0;
      checked_o = 0;
      hits_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) lookup_q.push_back(predict_lookup(fetch_address_i));
      if (out_valid_i && out_ready_i) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("result with no lookup outstanding, set", 32'(set_index_i), 0);
        end else begin
          want = lookup_q.pop_front();
          checked_o++;
          if (want.hit) hits_o++;
          if (hit_i !== want.hit) report_mismatch("hit", 32'(hit_i), 32'(want.hit));
          if (way_used_i !== want.way) begin
            report_mismatch("way_used", 32'(way_used_i), 32'(want.way));
          end
          if (set_index_i !== want.set_idx) begin
            report_mismatch("set_index", 32'(set_index_i), 32'(want.set_idx));
          end
        end
      end
    end
    pending_o = lookup_q.size();
  end

endmodule

// ----- verif/tb_set_assoc_cache_tag_lru.sv -----
// Testbench top: fetch-address stimulus, output pacing and the pass/fail verdict.
`timescale 1ns / 100ps

module tb_set_assoc_cache_tag_lru;
  import sacl_pkg::*;

  localparam int unsigned SetW        = $clog2(DefSets);
  localparam int unsigned OffW        = $clog2(DefLineBytes);
  localparam int unsigned TagW        = AddrW - OffW - SetW;
  localparam int unsigned HotCount    = 6;     // tags per hot set exceed the 4 ways
  localparam int unsigned PhaseItems  = 370;
  localparam int unsigned PressItems  = 45;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned SettleCyc   = 8;     // drain margin after the last lookup
  localparam int unsigned LimitCycles = 200000;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pacing_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [AddrW-1:0] fetch_address = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             hit;
  logic [1:0]       way_used;
  logic [5:0]       set_index;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned hits;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_armed = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;

  logic [TagW-1:0] hot_tag [HotCount];
  logic [SetW-1:0] hot_set [HotCount];

  always #2 clk = ~clk;

  set_assoc_cache_tag_lru u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .fetch_address_i (fetch_address),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .hit_o           (hit),
    .way_used_o      (way_used),
    .set_index_o     (set_index)
  );

  set_assoc_cache_tag_lru_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .fetch_address_i (fetch_address),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .hit_i           (hit),
    .way_used_i      (way_used),
    .set_index_i     (set_index),
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked),
    .hits_o          (hits)
  );

  // Result side. A hold request starts one long hold-off, counted here, during
  // which the block's two result slots fill and in_ready drops.
  always @(posedge clk) begin
    if (hold_req && !hold_armed) begin
      hold_armed <= 1'b1;
      hold_left  <= HoldCycles;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LimitCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [AddrW-1:0] make_addr(input logic [TagW-1:0] t,
                                                 input logic [SetW-1:0] s,
                                                 input logic [OffW-1:0] o);
    return {t, s, o};
  endfunction

  // Address from the hot pool: few sets, more tags than ways, so hits and
  // evictions both happen often.
  function automatic logic [AddrW-1:0] hot_address();
    return make_addr(hot_tag[$urandom_range(0, HotCount - 1)],
                     hot_set[$urandom_range(0, HotCount - 1)], OffW'($urandom()));
  endfunction

  // Called at a rising edge; returns at the edge that took the transaction,
  // or later if the sender idles. Idle cycles put noise on the address.
  task automatic offer_fetch(input logic [AddrW-1:0] addr);
    in_valid      <= 1'b1;
    fetch_address <= addr;
    do @(posedge clk); while (!in_ready);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid      <= 1'b0;
      fetch_address <= $urandom();
      @(posedge clk);
    end
  endtask

  // Sender pauses until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_pacing(input pacing_e mode);
    case (mode)
      PACE_FREE: begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      PACE_SEND_IDLE: begin
        send_idle_pct = 64;
        recv_stall_pct <= 0;
      end
      PACE_RECV_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct <= 64;
      end
      default: begin
        send_idle_pct = 20;
        recv_stall_pct <= 20;
      end
    endcase
  endtask

  // Mostly sequential fetch runs through hot lines, some scattered hot
  // lookups, the rest fully random addresses.
  task automatic run_random(input int unsigned n_items);
    int unsigned      left;
    int unsigned      pick;
    int unsigned      run_len;
    logic [AddrW-1:0] addr;
    left = n_items;
    while (left != 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run_len = $urandom_range(1, 12);
        if (run_len > left) run_len = left;
        addr = hot_address();
        addr[1:0] = 2'b00;
        repeat (run_len) begin
          offer_fetch(addr);
          addr = addr + 4;
        end
        left -= run_len;
      end else begin
        if (pick < 80) addr = hot_address();
        else addr = $urandom();
        offer_fetch(addr);
        left--;
      end
    end
  endtask

  initial begin
    logic [AddrW-1:0] directed_q[$];
    pacing_e          mode;

    for (int i = 0; i < HotCount; i++) begin
      hot_tag[i] = TagW'($urandom());
      hot_set[i] = SetW'($urandom());
    end

    // Tag zero on a fresh set matches the cleared tag of an invalid way:
    // must still miss. Then hit it, then miss and hit the all-ones line.
    directed_q.push_back(32'h0000_0000);
    directed_q.push_back(32'h0000_0000);
    directed_q.push_back(32'hFFFF_FFFF);
    directed_q.push_back(32'hFFFF_FFFC);
    directed_q.push_back(make_addr('0, SetW'(7), '0));
    // Fill set 5, reorder recency, then force evictions of the LRU way.
    for (int t = 1; t <= 4; t++) begin
      directed_q.push_back(make_addr(TagW'(t), SetW'(5), '0));
    end
    directed_q.push_back(make_addr(TagW'(2), SetW'(5), OffW'(4)));
    directed_q.push_back(make_addr(TagW'(5), SetW'(5), '0));
    directed_q.push_back(make_addr(TagW'(1), SetW'(5), OffW'(8)));
    directed_q.push_back(make_addr(TagW'(3), SetW'(5), 5'h1C));
    directed_q.push_back(make_addr(TagW'(4), SetW'(5), 5'h1F));   // fetch at the line end
    directed_q.push_back(make_addr(TagW'(5), SetW'(5), 5'h10));
    directed_q.push_back(make_addr(TagW'(2), SetW'(5), '0));
    directed_q.push_back(make_addr('1, SetW'(5), '0));
    directed_q.push_back(32'h8000_0000);
    directed_q.push_back(32'h7FFF_FFE0);
    directed_q.push_back(32'h7FFF_FFE0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The clearing pass after reset holds in_ready low; offer_fetch waits it out.
    set_pacing(PACE_FREE);
    foreach (directed_q[i]) offer_fetch(directed_q[i]);
    wait_drained();

    mode = PACE_FREE;
    repeat (4) begin
      set_pacing(mode);
      run_random(PhaseItems);
      wait_drained();
      mode = pacing_e'(mode + 1);
    end

    // Back-pressure: long output hold-off while the sender keeps offering.
    set_pacing(PACE_FREE);
    hold_req <= 1'b1;
    run_random(PressItems);
    wait_drained();

    repeat (SettleCyc) @(posedge clk);

    $display("Checked %0d fetch lookups (%0d hits, %0d misses) under free, sender-idle,",
             checked, hits, checked - hits);
    $display("receiver-stall and mixed pacing, plus a long output hold-off and drain pauses.");
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- set_assoc_cache_tag_lru.f -----
design/sacl_pkg.sv
design/sacl_way_sel.sv
design/set_assoc_cache_tag_lru.sv
verif/set_assoc_cache_tag_lru_checker.sv
verif/tb_set_assoc_cache_tag_lru.sv
